FILE: rtl/flow_name_hash_table_core_assert.svh
// Assertion macros shared by the flow table checker.
// No dependencies; include this header where assertions are written.
`ifndef FLOW_NAME_HASH_TABLE_CORE_ASSERT_SVH
`define FLOW_NAME_HASH_TABLE_CORE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define FNH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define FNH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/fnht_pkg.sv
// Package for the flow name hash table: field widths, codes and shared types.
// No dependencies.
package fnht_pkg;
  localparam int KeyW = 64;
  localparam int AddrW = 32;
  localparam int PortW = 16;
  localparam int OpW = 2;
  localparam int StW = 2;
  localparam int KeyBytes = 16;

  localparam logic [OpW-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OpW-1:0] OP_INSERT = 2'd1;
  localparam logic [OpW-1:0] OP_DELETE = 2'd2;
  localparam logic [OpW-1:0] OP_NONE = 2'd3;

  localparam logic [StW-1:0] ST_OK = 2'd0;
  localparam logic [StW-1:0] ST_FULL = 2'd1;
  localparam logic [StW-1:0] ST_DUP = 2'd2;
  localparam logic [StW-1:0] ST_MISS = 2'd3;

  localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;

  typedef struct packed {
    logic [OpW-1:0] operation;
    logic [KeyW-1:0] key_high;
    logic [KeyW-1:0] key_low;
    logic [AddrW-1:0] server_address;
    logic [PortW-1:0] media_udp;
    logic [AddrW-1:0] channel_address;
    logic [PortW-1:0] chan_udp;
  } req_t;

  typedef struct packed {
    logic [StW-1:0] status;
    logic [AddrW-1:0] found_server_address;
    logic [PortW-1:0] found_media_udp;
    logic [AddrW-1:0] found_channel_address;
    logic [PortW-1:0] found_chan_udp;
  } rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_HEAD, BK_RD, BK_CMP, BK_PREVRD, BK_FREE, BK_WRITE, BK_UNLINK, BK_DONE
  } bk_state_t;

  typedef enum logic [1:0] {FR_IDLE, FR_HASH, FR_MOD, FR_PUSH} fr_state_t;
endpackage

FILE: rtl/fnht_if.sv
// Valid/ready channel interface used for the item and result channels.
// Depends on nothing; payload type is a parameter.
interface fnht_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/fnht_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module fnht_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input logic clk,
  input logic we,
  input logic [$clog2(Depth)-1:0] waddr,
  input logic [Width-1:0] wdata,
  input logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/fnht_front.sv
// Front end: accepts items, hashes the 16-byte name one byte a cycle and
// reduces the hash to a bucket with a bit-serial remainder. Uses fnht_pkg.
module fnht_front import fnht_pkg::*; #(
  parameter int BucketW = 8
) (
  input logic clk,
  input logic rst_n,
  input logic [BucketW:0] bucket_n,
  input logic in_valid,
  output logic in_ready,
  input req_t in_data,
  output logic q_valid,
  input logic q_ready,
  output req_t q_req,
  output logic [BucketW-1:0] q_bucket
);
  localparam int KeyBits = 2 * KeyW;
  localparam int CntW = $clog2(KeyBytes + 1) > 6 ? $clog2(KeyBytes + 1) : 6;

  fr_state_t st_r, st_nxt;
  req_t req_r;
  logic [KeyBits-1:0] sh_r;
  logic [31:0] h_r;
  logic [CntW-1:0] cnt_r;
  logic [BucketW:0] rem_r;
  logic [BucketW:0] div_r;
  logic [BucketW+1:0] trial;
  logic [BucketW:0] n_eff;

  always_comb begin
    n_eff = bucket_n;
    if (bucket_n == '0) n_eff = {{BucketW{1'b0}}, 1'b1};
  end

  assign trial = {rem_r, h_r[31]} - {1'b0, div_r};
  assign in_ready = (st_r == FR_IDLE);
  assign q_valid = (st_r == FR_PUSH);
  assign q_req = req_r;
  assign q_bucket = rem_r[BucketW-1:0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      FR_IDLE: if (in_valid) st_nxt = FR_HASH;
      FR_HASH: if (cnt_r == CntW'(KeyBytes - 1)) st_nxt = FR_MOD;
      FR_MOD: if (cnt_r == CntW'(31)) st_nxt = FR_PUSH;
      FR_PUSH: if (q_ready) st_nxt = FR_IDLE;
      default: st_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FR_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    unique case (st_r)
      FR_IDLE: begin
        req_r <= in_data;
        sh_r <= {in_data.key_high, in_data.key_low};
        h_r <= '0;
        cnt_r <= '0;
        div_r <= n_eff;
      end
      FR_HASH: begin
        h_r <= (h_r << 5) - h_r + {24'd0, sh_r[KeyBits-1 -: 8]};
        sh_r <= sh_r << 8;
        cnt_r <= (cnt_r == CntW'(KeyBytes - 1)) ? '0 : cnt_r + 1'b1;
        rem_r <= '0;
      end
      FR_MOD: begin
        if (!trial[BucketW+1]) rem_r <= trial[BucketW:0];
        else rem_r <= {rem_r[BucketW-1:0], h_r[31]};
        h_r <= h_r << 1;
        cnt_r <= cnt_r + 1'b1;
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/fnht_back.sv
// Back end: walks the bucket chain in RAM, inserts, deletes, returns results.
// Uses fnht_pkg and fnht_ram.
module fnht_back import fnht_pkg::*; #(
  parameter int BucketW = 8,
  parameter int EntryW = 8
) (
  input logic clk,
  input logic rst_n,
  input logic q_valid,
  output logic q_ready,
  input req_t q_req,
  input logic [BucketW-1:0] q_bucket,
  output logic out_valid,
  input logic out_ready,
  output rsp_t out_data
);
  localparam int Pool = 1 << EntryW;
  localparam int Buckets = 1 << BucketW;
  localparam int PayW = 2 * KeyW + 2 * AddrW + 2 * PortW;
  localparam int ValW = 2 * AddrW + 2 * PortW;

  bk_state_t st_r, st_nxt;
  req_t req_r;
  logic [BucketW-1:0] bkt_r;
  logic [Buckets-1:0] hv_r;
  logic [EntryW:0] cur_r, prev_r, cnt_r, nx_r;
  logic [EntryW:0] free_cnt_r;
  logic [EntryW:0] fill_r;
  logic [EntryW-1:0] new_r;
  rsp_t rsp_r;
  rsp_t out_r;
  logic ov_r;
  logic done_go;

  logic head_we, pay_we, nxt_we, fl_we;
  logic [BucketW-1:0] head_ra;
  logic [EntryW:0] head_wd, head_rd, nxt_wd, nxt_rd;
  logic [EntryW-1:0] pay_ra, nxt_wa, nxt_ra, fl_wa, fl_ra, fl_wd, fl_rd;
  logic [PayW-1:0] pay_wd, pay_rd;
  logic [BucketW-1:0] head_wa;
  logic hit;

  fnht_ram #(.Width(EntryW+1), .Depth(Buckets)) u_head (.clk, .we(head_we),
    .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_rd));
  fnht_ram #(.Width(PayW), .Depth(Pool)) u_pay (.clk, .we(pay_we),
    .waddr(new_r), .wdata(pay_wd), .raddr(pay_ra), .rdata(pay_rd));
  fnht_ram #(.Width(EntryW+1), .Depth(Pool)) u_next (.clk, .we(nxt_we),
    .waddr(nxt_wa), .wdata(nxt_wd), .raddr(nxt_ra), .rdata(nxt_rd));
  fnht_ram #(.Width(EntryW), .Depth(Pool)) u_free (.clk, .we(fl_we),
    .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));

  // Bucket heads not yet written read as empty; free list positions below
  // the low-water mark were never written and hold their own index.
  logic [EntryW:0] head_val;
  logic [EntryW-1:0] free_val;
  logic fl_hv_r;
  assign head_val = hv_r[bkt_r] ? head_rd : (EntryW+1)'(Pool);
  assign free_val = fl_hv_r ? fl_rd : free_cnt_r[EntryW-1:0] - 1'b1;
  assign hit = (pay_rd[PayW-1 -: 2*KeyW] == {req_r.key_high, req_r.key_low});

  assign pay_wd = {req_r.key_high, req_r.key_low, req_r.server_address,
                   req_r.media_udp, req_r.channel_address, req_r.chan_udp};
  assign pay_ra = cur_r[EntryW-1:0];
  assign nxt_ra = cur_r[EntryW-1:0];
  // While idle the head read uses the incoming bucket, so the head is
  // ready in BK_HEAD.
  assign head_ra = (st_r == BK_IDLE) ? q_bucket : bkt_r;
  assign fl_ra = free_cnt_r[EntryW-1:0] - 1'b1;
  assign q_ready = (st_r == BK_IDLE);
  assign done_go = (st_r == BK_DONE) && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign out_data = out_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: if (q_valid) st_nxt = (q_req.operation == OP_NONE) ? BK_DONE : BK_HEAD;
      BK_HEAD: st_nxt = BK_RD;
      BK_RD: begin
        if (req_r.operation == OP_INSERT && free_cnt_r == '0) st_nxt = BK_DONE;
        else if (cur_r[EntryW] || cnt_r[EntryW])
          st_nxt = (req_r.operation == OP_INSERT) ? BK_FREE : BK_DONE;
        else st_nxt = BK_CMP;
      end
      BK_CMP: begin
        if (hit) begin
          if (req_r.operation == OP_DELETE) st_nxt = BK_UNLINK;
          else st_nxt = BK_DONE;
        end else st_nxt = BK_PREVRD;
      end
      BK_PREVRD: st_nxt = BK_RD;
      BK_FREE: st_nxt = BK_WRITE;
      BK_WRITE: st_nxt = BK_DONE;
      BK_UNLINK: st_nxt = BK_DONE;
      BK_DONE: if (done_go) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    head_we = 1'b0;
    head_wa = bkt_r;
    head_wd = {1'b0, new_r};
    pay_we = 1'b0;
    nxt_we = 1'b0;
    nxt_wa = new_r;
    nxt_wd = nx_r;
    fl_we = 1'b0;
    fl_wa = free_cnt_r[EntryW-1:0];
    fl_wd = cur_r[EntryW-1:0];
    unique case (st_r)
      BK_WRITE: begin
        head_we = 1'b1;
        pay_we = 1'b1;
        nxt_we = 1'b1;
        nxt_wd = nx_r;
      end
      BK_UNLINK: begin
        if (prev_r[EntryW]) begin
          head_we = 1'b1;
          head_wd = nxt_rd;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = prev_r[EntryW-1:0];
          nxt_wd = nxt_rd;
        end
        fl_we = !free_cnt_r[EntryW];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      hv_r <= '0;
      free_cnt_r <= (EntryW+1)'(Pool);
      fill_r <= (EntryW+1)'(Pool);
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= (ov_r && !out_ready) || done_go;
      if (head_we) hv_r[head_wa] <= 1'b1;
      if (st_r == BK_WRITE) begin
        free_cnt_r <= free_cnt_r - 1'b1;
        if (free_cnt_r <= fill_r) fill_r <= free_cnt_r - 1'b1;
      end
      if (st_r == BK_UNLINK && !free_cnt_r[EntryW]) free_cnt_r <= free_cnt_r + 1'b1;
    end
    fl_hv_r <= (free_cnt_r > fill_r);
    if (done_go) out_r <= rsp_r;
    unique case (st_r)
      BK_IDLE: begin
        req_r <= q_req;
        bkt_r <= q_bucket;
        cnt_r <= '0;
        prev_r <= (EntryW+1)'(Pool);
        rsp_r <= {ST_MISS, {ValW{1'b0}}};
      end
      BK_HEAD: cur_r <= head_val;
      BK_RD: begin
        nx_r <= head_val;
        if (req_r.operation == OP_INSERT && free_cnt_r == '0)
          rsp_r <= {ST_FULL, {ValW{1'b0}}};
      end
      BK_CMP: begin
        if (hit) begin
          if (req_r.operation == OP_LOOKUP) rsp_r <= {ST_OK, pay_rd[ValW-1:0]};
          else if (req_r.operation == OP_INSERT) rsp_r <= {ST_DUP, {ValW{1'b0}}};
          else rsp_r <= {ST_OK, {ValW{1'b0}}};
        end
      end
      BK_PREVRD: begin
        prev_r <= cur_r;
        cur_r <= nxt_rd;
        cnt_r <= cnt_r + 1'b1;
      end
      BK_FREE: new_r <= free_val;
      BK_WRITE: rsp_r.status <= ST_OK;
      default: ;
    endcase
  end
endmodule

FILE: rtl/flow_name_hash_table_core.sv
// Flow name hash table core. The time from input accept to result valid
// depends on the operation and grows with each chain entry passed. The
// front end takes a new item only after handing the last one to the back
// end, so items are taken at the pace of the byte-serial hash and the
// 32-step remainder, unless a chain walk runs longer. Synchronous active-low
// reset empties all buckets and refills the free pool at once, no clearing pass.
module flow_name_hash_table_core import fnht_pkg::*; (
  input logic clk,
  input logic rst_n,
  fnht_if.sink in_ch,
  fnht_if.source out_ch,
  input logic cfg_psel,
  input logic cfg_penable,
  input logic cfg_pwrite,
  input logic [1:0] cfg_paddr,
  input logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  localparam int BucketW = 8;
  localparam int EntryW = 8;

  // Bucket count register; zero is treated as one, values above the table
  // size are clipped to it.
  logic [8:0] bucket_count_r;
  logic [BucketW:0] bucket_n;
  logic q_valid, q_ready;
  req_t q_req;
  logic [BucketW-1:0] q_bucket;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1:0] == {REG_BUCKET_COUNT, 1'b0}) ?
                      {23'd0, bucket_count_r} : 32'd0;
  assign bucket_n = (bucket_count_r > 9'd256) ? 9'd256 : bucket_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= 9'd256;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == {REG_BUCKET_COUNT, 1'b0}) begin
      bucket_count_r <= cfg_pwdata[8:0];
    end
  end

  // The front end hashes and reduces the key while the back end works on
  // the previous item; the one-entry hand-off register is the queue.
  fnht_front #(.BucketW(BucketW)) u_front (
    .clk, .rst_n, .bucket_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid, .q_ready, .q_req, .q_bucket);

  fnht_back #(.BucketW(BucketW), .EntryW(EntryW)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_req, .q_bucket,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
endmodule

FILE: rtl/fnht_checker.sv
// Port-level checker for the flow table core, bound to the top level.
// Depends on fnht_pkg and the assertion macro header.
`include "flow_name_hash_table_core_assert.svh"
module fnht_checker import fnht_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [StW-1:0] out_status,
  input logic [AddrW-1:0] out_srv,
  input logic cfg_pready
);
  `FNH_ASSERT_IMP(a_ready_const, clk, rst_n, 1'b1, cfg_pready, "pready low")
  `FNH_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready,
    "input taken on consecutive cycles")
  `FNH_ASSERT_IMP(a_zero_on_miss, clk, rst_n, out_valid && out_status != ST_OK,
    out_srv == '0, "nonzero value without hit")
  `FNH_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
    "result dropped")
endmodule

bind flow_name_hash_table_core fnht_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.data.status), .out_srv(out_ch.data.found_server_address),
  .cfg_pready);
